>>> rtl/prpm_pkg.sv
// ----------------------------------------------------------------------------
// prpm_pkg: shared types and constants of the pump rotation period monitor
// Status codes, controller command and status bundles, fixed arithmetic
// constants for the tolerance check and the rate divider.
// ----------------------------------------------------------------------------
package prpm_pkg;

	// Field widths
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned RATE_W   = 13;
	localparam int unsigned STATE_W  = 3;

	// Default tick length in ms
	localparam int unsigned TICK_MS_DEF = 5;

	// Tolerance check: 100*period against 101*expected and 99*expected
	localparam int unsigned CMP_W = PERIOD_W + 7;
	localparam logic [CMP_W-1:0] PCT_ONE = CMP_W'(100);
	localparam logic [CMP_W-1:0] PCT_HI  = CMP_W'(101);
	localparam logic [CMP_W-1:0] PCT_LO  = CMP_W'(99);

	// Rate divider: 60000 / period, one quotient bit per step
	localparam logic [PERIOD_W-1:0] RATE_NUM = PERIOD_W'(60000);
	localparam int unsigned DIV_CNT_W = $clog2(PERIOD_W);
	localparam logic [RATE_W-1:0] RATE_MAX = '1;

	// Rotations counter saturates here; running needs more than two
	localparam logic [1:0] ROT_MAX = 2'd3;

	// Reported pump status
	typedef enum logic [STATE_W-1:0] {
		ST_IDLE    = 3'd0,
		ST_STARTED = 3'd1,
		ST_RUNNING = 3'd2,
		ST_SLOW    = 3'd3,
		ST_FAST    = 3'd4,
		ST_NORMAL  = 3'd5
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // take the input beat, update counters
		logic eval;      // classify speed, seed divider
		logic div_step;  // one restoring divide step
		logic push;      // load the result register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic edge_hit;  // beat carries an armed falling edge
		logic div_last;  // current divide step is the final one
	} sts_t;

endpackage

>>> rtl/prpm_in_if.sv
// ----------------------------------------------------------------------------
// prpm_in_if: input item channel
// Valid/ready channel carrying one tick or start command per beat.
// ----------------------------------------------------------------------------
interface prpm_in_if;
	logic valid;
	logic ready;
	logic func;
	logic marker;

	modport source (output valid, output func, output marker, input ready);
	modport sink   (input valid, input func, input marker, output ready);
endinterface

>>> rtl/prpm_out_if.sv
// ----------------------------------------------------------------------------
// prpm_out_if: result channel
// Valid/ready channel carrying one status report per beat.
// ----------------------------------------------------------------------------
interface prpm_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         pump_state;
	logic [15:0]        period_ms;
	logic signed [15:0] period_delta;
	logic [12:0]        rate_per_min;

	modport source (output valid, output pump_state, output period_ms,
		output period_delta, output rate_per_min, input ready);
	modport sink   (input valid, input pump_state, input period_ms,
		input period_delta, input rate_per_min, output ready);
endinterface

>>> rtl/prpm_ctrl.sv
// ----------------------------------------------------------------------------
// prpm_ctrl: sequencing controller
// Accepts one beat at a time, runs classification and the divide on a
// measured edge, then hands the result to the output register.
// ----------------------------------------------------------------------------
module prpm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	output logic            result_valid,
	input  logic            result_ready,
	input  prpm_pkg::sts_t  sts,
	output prpm_pkg::cmd_t  cmd
);
	import prpm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_DIV  = 4'b0100,
		S_PUSH = 4'b1000
	} fsm_t;

	fsm_t state_q, state_nxt;
	logic out_valid_q;

	// Next state and commands
	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load  = 1'b1;
					state_nxt = sts.edge_hit ? S_EVAL : S_PUSH;
				end
			end
			S_EVAL: begin
				cmd.eval  = 1'b1;
				state_nxt = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_nxt = S_PUSH;
				end
			end
			S_PUSH: begin
				if (!out_valid_q || result_ready) begin
					cmd.push  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Hold result valid until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;

endmodule

>>> rtl/prpm_dp.sv
// ----------------------------------------------------------------------------
// prpm_dp: measurement datapath
// Tick counter, edge detect, period latch, tolerance compare, restoring
// divider for the rate, expected-period register and result register.
// ----------------------------------------------------------------------------
module prpm_dp #(
	parameter int unsigned TICK_MS = prpm_pkg::TICK_MS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [prpm_pkg::PERIOD_W-1:0]      cfg_wdata,
	input  logic                               func,
	input  logic                               marker,
	input  prpm_pkg::cmd_t                     cmd,
	output prpm_pkg::sts_t                     sts,
	output logic [prpm_pkg::STATE_W-1:0]       res_state,
	output logic [prpm_pkg::PERIOD_W-1:0]      res_period,
	output logic signed [prpm_pkg::PERIOD_W-1:0] res_delta,
	output logic [prpm_pkg::RATE_W-1:0]        res_rate
);
	import prpm_pkg::*;

	localparam int unsigned TW     = $clog2(TICK_MS + 1);
	localparam int unsigned PROD_W = PERIOD_W + TW;

	// Measurement state
	status_t               status_q;
	logic                  armed_q;
	logic                  last_marker_q;
	logic [PERIOD_W-1:0]   tick_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [1:0]            rot_q;
	logic [RATE_W-1:0]     rate_q;
	logic [PERIOD_W-1:0]   expected_q;

	// Divider
	logic [PERIOD_W-1:0]   rem_q;
	logic [PERIOD_W-1:0]   quot_q;
	logic [DIV_CNT_W-1:0]  cnt_q;

	logic                  fall;
	logic [PERIOD_W-1:0]   tick_inc;
	logic [PROD_W-1:0]     prod;
	logic [PERIOD_W-1:0]   period_new;
	logic [CMP_W-1:0]      lhs;
	logic [CMP_W-1:0]      rhs_hi;
	logic [CMP_W-1:0]      rhs_lo;
	logic [PERIOD_W:0]     trial;
	logic                  qbit;
	logic [PERIOD_W-1:0]   rem_nxt;
	logic [PERIOD_W-1:0]   quot_nxt;
	logic [RATE_W-1:0]     rate_sat;

	// Edge detect and period in ms
	assign fall     = !func && !marker && last_marker_q;
	assign tick_inc = (tick_q == '1) ? tick_q : tick_q + PERIOD_W'(1);
	assign prod     = PROD_W'(tick_inc) * PROD_W'(TICK_MS);
	assign period_new = (|prod[PROD_W-1:PERIOD_W]) ? '1 : prod[PERIOD_W-1:0];

	assign sts.edge_hit = fall && armed_q;
	assign sts.div_last = (cnt_q == '1);

	// Tolerance products
	assign lhs    = CMP_W'(period_q) * PCT_ONE;
	assign rhs_hi = CMP_W'(expected_q) * PCT_HI;
	assign rhs_lo = CMP_W'(expected_q) * PCT_LO;

	// One restoring divide step
	assign trial    = {rem_q, quot_q[PERIOD_W-1]};
	assign qbit     = (trial >= {1'b0, period_q});
	assign rem_nxt  = qbit ? PERIOD_W'(trial - {1'b0, period_q}) : trial[PERIOD_W-1:0];
	assign quot_nxt = {quot_q[PERIOD_W-2:0], qbit};
	assign rate_sat = (|quot_nxt[PERIOD_W-1:RATE_W]) ? RATE_MAX : quot_nxt[RATE_W-1:0];

	// Expected period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
		end else if (cfg_we) begin
			expected_q <= cfg_wdata;
		end
	end

	// Measurement state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q      <= ST_IDLE;
			armed_q       <= 1'b0;
			last_marker_q <= 1'b1;
			tick_q        <= '0;
			period_q      <= '0;
			rot_q         <= '0;
			rate_q        <= '0;
			cnt_q         <= '0;
		end else begin
			if (cmd.load) begin
				if (func) begin
					status_q <= ST_STARTED;
				end else begin
					tick_q        <= tick_inc;
					last_marker_q <= marker;
					if (status_q == ST_STARTED && rot_q == ROT_MAX) begin
						status_q <= ST_RUNNING;
					end
					if (fall) begin
						tick_q <= '0;
						if (!armed_q) begin
							armed_q <= 1'b1;
						end else begin
							period_q <= period_new;
							if (rot_q != ROT_MAX) begin
								rot_q <= rot_q + 2'd1;
							end
						end
					end
				end
			end
			// Classify speed unless just started
			if (cmd.eval) begin
				cnt_q <= '0;
				if (status_q != ST_STARTED) begin
					priority if (lhs > rhs_hi) begin
						status_q <= ST_SLOW;
					end else if (lhs < rhs_lo) begin
						status_q <= ST_FAST;
					end else begin
						status_q <= ST_NORMAL;
					end
				end
			end
			// Advance divider, latch rate on the final step
			if (cmd.div_step) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (sts.div_last) begin
					rate_q <= rate_sat;
				end
			end
		end
	end

	// Divider payload
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			rem_q  <= '0;
			quot_q <= RATE_NUM;
		end else if (cmd.div_step) begin
			rem_q  <= rem_nxt;
			quot_q <= quot_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			res_state  <= status_q;
			res_period <= period_q;
			res_delta  <= $signed(period_q - expected_q);
			res_rate   <= rate_q;
		end
	end

endmodule

>>> rtl/pump_rotation_period_monitor.sv
// ----------------------------------------------------------------------------
// pump_rotation_period_monitor: rotation period tachometer for a pump
// Measures ticks between marker falling edges, reports status, period,
// deviation from the expected period and rotations per minute.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one beat per tick (func 0, marker sample) or start (func 1).
//   result : exactly one status report per accepted item, in order.
//   cfg_we/cfg_wdata : expected period in ms; write only while idle.
// Sequence:
//   A tick without a measured edge, or a start, is latched on acceptance
//   and then loaded into the result register. A tick that closes a rotation
//   is latched, classified, run through 16 steps of the restoring divider
//   that forms 60000 / period, then loaded into the result register.
//   Items are processed one at a time.
// Reset:
//   Status idle, not armed, marker history high, counters and period zero,
//   expected period zero. No clearing pass is needed.
// Stall:
//   A finished result waits in the output register; the next item is
//   accepted and processed meanwhile, and its result loads once taken.
// ----------------------------------------------------------------------------
module pump_rotation_period_monitor #(
	parameter int unsigned TICK_MS = prpm_pkg::TICK_MS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [prpm_pkg::PERIOD_W-1:0] cfg_wdata,
	prpm_in_if.sink                       item,
	prpm_out_if.source                    result
);
	import prpm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	prpm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	prpm_dp #(
		.TICK_MS (TICK_MS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.func       (item.func),
		.marker     (item.marker),
		.cmd        (cmd),
		.sts        (sts),
		.res_state  (result.pump_state),
		.res_period (result.period_ms),
		.res_delta  (result.period_delta),
		.res_rate   (result.rate_per_min)
	);

	// No second beat while one is in work
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("second item accepted while busy");

	// Divider never runs while the input side is open
	a_div_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !cmd.div_step && !cmd.eval)
		else $error("divider active while idle");

	// A result is loaded only into a free or draining output register
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !result.valid || result.ready)
		else $error("result overwritten before taken");

endmodule
